>>> hw/rtl/lch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lch_pkg;

  // Fixed field widths of the channels.
  localparam int CMD_W     = 2;
  localparam int PIX_W     = 8;
  localparam int BIN_IDX_W = 8;
  localparam int OUT_W     = 20;
  localparam int OFFSET_W  = 8;

  // Command codes carried in the cmd field.
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Offset register value after reset.
  localparam logic [OFFSET_W-1:0] CHROMA_OFFSET_RST = 8'd91;

  // Natural log table format: unsigned Q3.28.
  localparam int LN_W     = 31;
  localparam int LOG_FRAC = 28;
  localparam logic [63:0] LN2_Q32 = 64'd2977044472;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // load the accepted item
    logic rd_pix;     // read the bin chosen by the pixel
    logic wr_pix;     // write back the incremented count
    logic rd_bin;     // read the bin named by the read command
    logic clr_start;  // restart the clear sweep
    logic clr_step;   // zero one bin and advance
    logic out_load;   // load the result register
  } lch_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;   // sweep is at the last bin
  } lch_status_t;

  // ln x in Q3.28, built by repeated squaring of the log2 mantissa.
  // Only evaluated at elaboration to fill the log table; ln 0 maps to 0.
  function automatic logic [LN_W-1:0] ln_q28(input logic [PIX_W-1:0] x);
    logic [2:0]  m;
    logic [63:0] y;
    logic [63:0] l2;
    logic [63:0] prod;
    m = 3'd0;
    for (int k = 1; k < PIX_W; k++) begin
      if (x[k]) begin
        m = 3'(k);
      end
    end
    y  = ({56'd0, x} << 30) >> m;
    l2 = {61'd0, m} << LOG_FRAC;
    for (int i = LOG_FRAC - 1; i >= 0; i--) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y  = y >> 1;
        l2 = l2 | (64'd1 << i);
      end
    end
    prod = l2 * LN2_Q32 + (64'd1 << 31);
    return LN_W'(prod >> 32);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lch_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: pixel, read or clear item.
interface lch_req_if;
  logic                           valid;
  logic                           ready;
  logic [lch_pkg::CMD_W-1:0]      cmd;
  logic [lch_pkg::PIX_W-1:0]      red;
  logic [lch_pkg::PIX_W-1:0]      green;
  logic [lch_pkg::PIX_W-1:0]      blue;
  logic [lch_pkg::BIN_IDX_W-1:0]  bin_u;
  logic [lch_pkg::BIN_IDX_W-1:0]  bin_v;

  modport source (output valid, cmd, red, green, blue, bin_u, bin_v, input ready);
  modport sink   (input valid, cmd, red, green, blue, bin_u, bin_v, output ready);
endinterface

// Response channel: one bin count per read item.
interface lch_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [lch_pkg::OUT_W-1:0]  bin_count;

  modport source (output valid, bin_count, input ready);
  modport sink   (input valid, bin_count, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/log_chroma_histogram_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                   Handshake
// req       in   cmd, red, green, blue, bin_u, bin_v       valid/ready
// rsp       out  bin_count                                 valid/ready
// cfg       in   cfg_wr_data (chroma_offset)               cfg_wr_en
//
// A pixel item passes through capture, five pipeline stages to the bin address,
// then a read and a write of the histogram memory. A read item passes through
// capture, a memory read and the result load, which waits for the result
// register to drain. A clear item zeroes all 2^(2*ceil(log2 BINS_PER_AXIS))
// bins, one bin per cycle; reset runs the same sweep with req.ready low.
// A waiting result stalls only the next read item, not pixel or clear items.

module log_chroma_histogram_core #(
  parameter int BINS_PER_AXIS     = 256,
  parameter int COUNT_BITS        = 20,
  parameter int BINS_PER_LOG_UNIT = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  lch_req_if.sink                              req,
  lch_rsp_if.source                            rsp,
  input  wire logic                            cfg_wr_en,
  input  wire logic [lch_pkg::OFFSET_W-1:0]    cfg_wr_data
);

  logic [lch_pkg::OFFSET_W-1:0] chroma_offset;
  lch_pkg::lch_cmd_t            cmd;
  lch_pkg::lch_status_t         status;

  // Offset register.
  always_ff @(posedge clk) begin
    if (rst) begin
      chroma_offset <= lch_pkg::CHROMA_OFFSET_RST;
    end else if (cfg_wr_en) begin
      chroma_offset <= cfg_wr_data;
    end
  end

  // Sequencer.
  lch_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Log pipeline and histogram store.
  lch_datapath #(
    .BINS_PER_AXIS     (BINS_PER_AXIS),
    .COUNT_BITS        (COUNT_BITS),
    .BINS_PER_LOG_UNIT (BINS_PER_LOG_UNIT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .red           (req.red),
    .green         (req.green),
    .blue          (req.blue),
    .bin_u         (req.bin_u),
    .bin_v         (req.bin_v),
    .chroma_offset (chroma_offset),
    .bin_count     (rsp.bin_count)
  );

endmodule

`default_nettype wire

>>> hw/rtl/lch_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module lch_datapath #(
  parameter int BINS_PER_AXIS     = 256,
  parameter int COUNT_BITS        = 20,
  parameter int BINS_PER_LOG_UNIT = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire lch_pkg::lch_cmd_t                  cmd,
  output      lch_pkg::lch_status_t               status,
  input  wire logic [lch_pkg::PIX_W-1:0]          red,
  input  wire logic [lch_pkg::PIX_W-1:0]          green,
  input  wire logic [lch_pkg::PIX_W-1:0]          blue,
  input  wire logic [lch_pkg::BIN_IDX_W-1:0]      bin_u,
  input  wire logic [lch_pkg::BIN_IDX_W-1:0]      bin_v,
  input  wire logic [lch_pkg::OFFSET_W-1:0]       chroma_offset,
  output      logic [lch_pkg::OUT_W-1:0]          bin_count
);

  localparam int AW        = $clog2(BINS_PER_AXIS);
  localparam int MW        = 2 * AW;
  localparam int MEM_DEPTH = 1 << MW;
  localparam int LN_W      = lch_pkg::LN_W;
  localparam int DW        = LN_W + 1;
  localparam int KW        = $clog2(BINS_PER_LOG_UNIT + 1) + 1;
  localparam int PW        = DW + KW;
  localparam int RW        = PW - lch_pkg::LOG_FRAC + 1;
  localparam int ROM_DEPTH = 1 << lch_pkg::PIX_W;

  localparam logic signed [PW-1:0] K_S        = PW'(BINS_PER_LOG_UNIT);
  localparam logic [PW:0]          ROUND_HALF = (PW + 1)'(1) << (lch_pkg::LOG_FRAC - 1);
  localparam logic signed [RW:0]   TOP_S      = (RW + 1)'(BINS_PER_AXIS - 1);
  localparam logic [AW-1:0]        TOP_IDX    = AW'(BINS_PER_AXIS - 1);

  // Natural log table, one constant per pixel level.
  logic [LN_W-1:0] ln_rom [ROM_DEPTH];

  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_ln_rom
    localparam logic [LN_W-1:0] LN_E = lch_pkg::ln_q28(lch_pkg::PIX_W'(g));
    assign ln_rom[g] = LN_E;
  end

  // Captured item.
  logic [lch_pkg::PIX_W-1:0]     red_r, green_r, blue_r;
  logic [lch_pkg::BIN_IDX_W-1:0] bin_u_r, bin_v_r;

  // Pixel pipeline stages.
  logic [LN_W-1:0]        ln_g, ln_r, ln_b;
  logic signed [DW-1:0]   diff_u, diff_v;
  logic signed [PW-1:0]   prod_u, prod_v;
  logic signed [RW-1:0]   round_u, round_v;
  logic [AW-1:0]          idx_u, idx_v;

  // Histogram store and its access signals.
  logic [COUNT_BITS-1:0]  hist_mem [MEM_DEPTH];
  logic [COUNT_BITS-1:0]  rd_data;
  logic [COUNT_BITS-1:0]  sat_inc;
  logic [COUNT_BITS-1:0]  wr_data;
  logic [MW-1:0]          pix_addr;
  logic [MW-1:0]          bin_addr;
  logic [MW-1:0]          rd_addr;
  logic [MW-1:0]          wr_addr;
  logic [MW-1:0]          clr_addr;
  logic                   wr_en;
  logic                   rd_en;
  logic                   bin_in_range;
  logic                   bin_ok;

  // Rounds a Q.28 product half away from zero to an integer.
  function automatic logic signed [RW-1:0] round_q(input logic signed [PW-1:0] p);
    logic [PW-1:0] mag;
    logic [PW:0]   sum;
    logic [RW-1:0] q;
    logic signed [RW-1:0] qs;
    mag = p[PW-1] ? PW'(-p) : PW'(p);
    sum = {1'b0, mag} + ROUND_HALF;
    q   = sum[PW:lch_pkg::LOG_FRAC];
    qs  = $signed({1'b0, q[RW-2:0]});
    return p[PW-1] ? -qs : qs;
  endfunction

  // Adds the offset and clamps; a zero channel on one side only forces an edge bin.
  function automatic logic [AW-1:0] axis_idx(input logic signed [RW-1:0] r,
                                              input logic min_zero,
                                              input logic sub_zero,
                                              input logic [lch_pkg::OFFSET_W-1:0] offs);
    logic signed [RW:0] sum;
    logic [AW-1:0]      idx;
    sum = $signed((RW + 1)'(r)) + $signed({{(RW + 1 - lch_pkg::OFFSET_W){1'b0}}, offs});
    if (sum < 0) begin
      idx = '0;
    end else if (sum > TOP_S) begin
      idx = TOP_IDX;
    end else begin
      idx = AW'(sum);
    end
    if (min_zero && !sub_zero) begin
      idx = '0;
    end else if (sub_zero && !min_zero) begin
      idx = TOP_IDX;
    end
    return idx;
  endfunction

  // Item capture; held until the next accepted item.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      red_r   <= red;
      green_r <= green;
      blue_r  <= blue;
      bin_u_r <= bin_u;
      bin_v_r <= bin_v;
    end
  end

  // Pixel pipeline: log lookup, difference, scale, round, offset and clamp.
  always_ff @(posedge clk) begin
    ln_g    <= ln_rom[green_r];
    ln_r    <= ln_rom[red_r];
    ln_b    <= ln_rom[blue_r];
    diff_u  <= $signed({1'b0, ln_g}) - $signed({1'b0, ln_r});
    diff_v  <= $signed({1'b0, ln_g}) - $signed({1'b0, ln_b});
    prod_u  <= PW'(diff_u) * K_S;
    prod_v  <= PW'(diff_v) * K_S;
    round_u <= round_q(prod_u);
    round_v <= round_q(prod_v);
    idx_u   <= axis_idx(round_u, green_r == '0, red_r == '0, chroma_offset);
    idx_v   <= axis_idx(round_v, green_r == '0, blue_r == '0, chroma_offset);
  end

  // Address and data selection for the store.
  assign pix_addr     = {idx_u, idx_v};
  assign bin_addr     = {AW'(bin_u_r), AW'(bin_v_r)};
  assign bin_in_range = (32'(bin_u_r) < 32'(BINS_PER_AXIS)) &&
                        (32'(bin_v_r) < 32'(BINS_PER_AXIS));
  assign rd_en        = cmd.rd_pix || cmd.rd_bin;
  assign rd_addr      = cmd.rd_bin ? bin_addr : pix_addr;
  assign sat_inc      = (rd_data == '1) ? rd_data : rd_data + 1'b1;
  assign wr_en        = cmd.wr_pix || cmd.clr_step;
  assign wr_addr      = cmd.clr_step ? clr_addr : pix_addr;
  assign wr_data      = cmd.clr_step ? '0 : sat_inc;

  // Histogram store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= hist_mem[rd_addr];
    end
  end

  // Range flag of the read command follows its memory read.
  always_ff @(posedge clk) begin
    if (cmd.rd_bin) begin
      bin_ok <= bin_in_range;
    end
  end

  // Clear sweep address.
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign status.clr_last = (clr_addr == '1);

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      bin_count <= bin_ok ? lch_pkg::OUT_W'(rd_data) : '0;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lch_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lch_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  input  wire logic [lch_pkg::CMD_W-1:0]     req_cmd,
  output      logic                          req_ready,
  output      logic                          rsp_valid,
  input  wire logic                          rsp_ready,
  output      lch_pkg::lch_cmd_t             cmd,
  input  wire lch_pkg::lch_status_t          status
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CLEAR    = 3'd1;
  localparam logic [2:0] S_PIX_WAIT = 3'd2;
  localparam logic [2:0] S_PIX_RD   = 3'd3;
  localparam logic [2:0] S_PIX_WR   = 3'd4;
  localparam logic [2:0] S_BIN_RD   = 3'd5;
  localparam logic [2:0] S_BIN_OUT  = 3'd6;

  // Last wait step before the pixel pipeline's bin address is ready.
  localparam logic [2:0] PIX_WAIT_LAST = 3'd4;

  logic [2:0] state, state_next;
  logic [2:0] step, step_next;
  logic       accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          unique case (req_cmd)
            lch_pkg::CMD_ADD: begin
              state_next = S_PIX_WAIT;
              step_next  = '0;
            end
            lch_pkg::CMD_READ: begin
              state_next = S_BIN_RD;
            end
            lch_pkg::CMD_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_next    = S_CLEAR;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_PIX_WAIT: begin
        step_next = step + 1'b1;
        if (step == PIX_WAIT_LAST) begin
          state_next = S_PIX_RD;
        end
      end
      S_PIX_RD: begin
        cmd.rd_pix = 1'b1;
        state_next = S_PIX_WR;
      end
      S_PIX_WR: begin
        cmd.wr_pix = 1'b1;
        state_next = S_IDLE;
      end
      S_BIN_RD: begin
        cmd.rd_bin = 1'b1;
        state_next = S_BIN_OUT;
      end
      S_BIN_OUT: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers; reset starts with a full clear sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/tb_log_chroma_histogram_core.sv
`timescale 1ns / 1ps

module tb_log_chroma_histogram_core;

  localparam int CMD_W     = lch_pkg::CMD_W;
  localparam int PIX_W     = lch_pkg::PIX_W;
  localparam int BIN_IDX_W = lch_pkg::BIN_IDX_W;
  localparam int OUT_W     = lch_pkg::OUT_W;
  localparam int OFFSET_W  = lch_pkg::OFFSET_W;
  localparam logic [CMD_W-1:0]    CMD_ADD           = lch_pkg::CMD_ADD;
  localparam logic [CMD_W-1:0]    CMD_READ          = lch_pkg::CMD_READ;
  localparam logic [CMD_W-1:0]    CMD_CLEAR         = lch_pkg::CMD_CLEAR;
  localparam logic [OFFSET_W-1:0] CHROMA_OFFSET_RST = lch_pkg::CHROMA_OFFSET_RST;

  localparam int CLK_HALF     = 4;
  localparam int BINS         = 256;
  localparam int LOG_SCALE    = 64;
  localparam int LN_FRAC_BITS = 28;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int PHASE_ITEMS  = 63;
  localparam int HIT_DEPTH    = 32;
  localparam logic [63:0] LN2_FIXED = 64'd2977044472;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [OUT_W-1:0] COUNT_FULL = {OUT_W{1'b1}};

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [PIX_W-1:0]     red;
    logic [PIX_W-1:0]     green;
    logic [PIX_W-1:0]     blue;
    logic [BIN_IDX_W-1:0] bin_u;
    logic [BIN_IDX_W-1:0] bin_v;
  } hist_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [OFFSET_W-1:0] cfg_wr_data = '0;

  lch_req_if req_ch ();
  lch_rsp_if rsp_ch ();

  // Histogram copy kept alongside the block, plus the offset it currently uses.
  logic [OUT_W-1:0]    bin_model [0:BINS*BINS-1];
  logic [OFFSET_W-1:0] offset_model;

  hist_item_t       pending_items [$];
  logic [OUT_W-1:0] expected_counts [$];
  logic [15:0]      hit_bins [$];
  hist_item_t       next_item;

  int items_issued = 0;
  int items_accepted = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int clears_left = 2;
  int tx_gap = 0;
  int tx_burst = 0;
  int rx_hold = 0;
  int rx_mode = 0;
  bit item_taken = 1'b0;

  log_chroma_histogram_core #(
    .BINS_PER_AXIS(BINS),
    .COUNT_BITS(OUT_W),
    .BINS_PER_LOG_UNIT(LOG_SCALE)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Natural log in Q3.28: integer part of log2 from the leading one, fraction
  // bits by repeated squaring of the mantissa, then scaled by ln 2.
  function automatic longint ln_fixed(input logic [PIX_W-1:0] x);
    logic [63:0] mant;
    logic [63:0] lg2;
    int lead;
    int k;
    lead = 0;
    for (k = 1; k < PIX_W; k++) begin
      if (x[k]) begin
        lead = k;
      end
    end
    mant = ({56'd0, x} << 30) >> lead;
    lg2 = 64'(lead) << LN_FRAC_BITS;
    for (k = LN_FRAC_BITS - 1; k >= 0; k--) begin
      mant = (mant * mant) >> 30;
      if (mant >= (64'd2 << 30)) begin
        mant = mant >> 1;
        lg2[k] = 1'b1;
      end
    end
    return longint'((lg2 * LN2_FIXED + (64'd1 << 31)) >> 32);
  endfunction

  // Clamped bin index for ln(num) - ln(den) plus the offset.
  function automatic logic [BIN_IDX_W-1:0] chroma_bin(input logic [PIX_W-1:0] num,
                                                     input logic [PIX_W-1:0] den,
                                                     input logic [OFFSET_W-1:0] ofs);
    longint scaled;
    longint mag;
    longint steps;
    longint idx;
    // A zero channel acts as minus infinity on its own side.
    if (num == 0 && den != 0) begin
      return '0;
    end
    if (den == 0 && num != 0) begin
      return BIN_IDX_W'(BINS - 1);
    end
    steps = 0;
    if (num != 0) begin
      scaled = (ln_fixed(num) - ln_fixed(den)) * LOG_SCALE;
      mag = (scaled < 0) ? -scaled : scaled;
      steps = (mag + (longint'(1) << (LN_FRAC_BITS - 1))) >>> LN_FRAC_BITS;
      if (scaled < 0) begin
        steps = -steps;
      end
    end
    idx = steps + longint'(ofs);
    if (idx < 0) begin
      idx = 0;
    end
    if (idx > BINS - 1) begin
      idx = BINS - 1;
    end
    return BIN_IDX_W'(idx);
  endfunction

  task automatic clear_bin_model;
    int k;
    for (k = 0; k < BINS * BINS; k++) begin
      bin_model[k] = '0;
    end
  endtask

  // Apply one accepted item to the histogram copy.
  task automatic update_histogram_model(input hist_item_t it);
    logic [BIN_IDX_W-1:0] row;
    logic [BIN_IDX_W-1:0] col;
    case (it.cmd)
      CMD_ADD: begin
        row = chroma_bin(it.green, it.red, offset_model);
        col = chroma_bin(it.green, it.blue, offset_model);
        if (bin_model[{row, col}] != COUNT_FULL) begin
          bin_model[{row, col}] = bin_model[{row, col}] + 1'b1;
        end
      end
      CMD_READ: begin
        expected_counts.push_back(bin_model[{it.bin_u, it.bin_v}]);
      end
      CMD_CLEAR: begin
        clear_bin_model();
      end
      default: begin
      end
    endcase
  endtask

  // Rising edge: compare results, then track accepted items and register writes.
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    cycle_count = cycle_count + 1;
    if (rst) begin
      clear_bin_model();
      offset_model = CHROMA_OFFSET_RST;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_counts.size() == 0) begin
          $error("bin_count: expected none, actual %0d", rsp_ch.bin_count);
          fail_count++;
        end else begin
          want = expected_counts.pop_front();
          if (rsp_ch.bin_count !== want) begin
            $error("bin_count mismatch: expected %0d, actual %0d", want, rsp_ch.bin_count);
            fail_count++;
          end
        end
      end
      if (cfg_wr_en) begin
        offset_model = cfg_wr_data;
      end
      if (req_ch.valid && req_ch.ready) begin
        item_taken = 1'b1;
        items_accepted++;
        update_histogram_model('{req_ch.cmd, req_ch.red, req_ch.green, req_ch.blue,
                                 req_ch.bin_u, req_ch.bin_v});
      end
    end
  end

  // Request driver: bursts of items with random gaps between them.
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || item_taken) begin
      item_taken = 1'b0;
      if (tx_gap != 0) begin
        req_ch.valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (pending_items.size() != 0) begin
        next_item = pending_items.pop_front();
        req_ch.cmd   <= next_item.cmd;
        req_ch.red   <= next_item.red;
        req_ch.green <= next_item.green;
        req_ch.blue  <= next_item.blue;
        req_ch.bin_u <= next_item.bin_u;
        req_ch.bin_v <= next_item.bin_v;
        req_ch.valid <= 1'b1;
        if (tx_burst <= 1) begin
          tx_burst <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
          tx_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          tx_burst <= tx_burst - 1;
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: always ready, coin-flip ready, or long stalls, in randomly chosen modes.
  always @(negedge clk) begin
    if (cycle_count % 200 == 0) begin
      rx_mode <= $urandom_range(0, 2);
    end
    if (rx_hold != 0) begin
      rsp_ch.ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      case (rx_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            rx_hold <= $urandom_range(1, 24);
          end else begin
            rsp_ch.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  task automatic queue_item(input logic [CMD_W-1:0] cmd, input logic [PIX_W-1:0] r,
                            input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b,
                            input logic [BIN_IDX_W-1:0] u, input logic [BIN_IDX_W-1:0] v);
    pending_items.push_back('{cmd, r, g, b, u, v});
    items_issued++;
  endtask

  // Pixel item; its bin is remembered so that later reads can find it.
  task automatic queue_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                             input logic [PIX_W-1:0] b);
    queue_item(CMD_ADD, r, g, b, 8'($urandom), 8'($urandom));
    hit_bins.push_back({chroma_bin(g, r, offset_model), chroma_bin(g, b, offset_model)});
    if (hit_bins.size() > HIT_DEPTH) begin
      void'(hit_bins.pop_front());
    end
  endtask

  task automatic queue_read(input logic [BIN_IDX_W-1:0] u, input logic [BIN_IDX_W-1:0] v);
    queue_item(CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom), u, v);
  endtask

  task automatic queue_clear;
    queue_item(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom), 8'($urandom));
  endtask

  // Channel value biased toward zero and full scale.
  function automatic logic [PIX_W-1:0] rand_channel;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic write_offset(input logic [OFFSET_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Each phase ends with a read, so an empty expectation queue means the
  // block has finished everything before it; a short pause covers the rest.
  task automatic wait_idle;
    do begin
      @(negedge clk);
    end while (items_accepted != items_issued || expected_counts.size() != 0);
    repeat (16) @(negedge clk);
  endtask

  // Random mix: pixels, many from a small palette so bins build up counts,
  // reads mostly of bins already hit, rare clears and some unused commands.
  task automatic queue_random_phase(input int n_items);
    logic [23:0] palette [8];
    logic [23:0] color;
    logic [15:0] spot;
    int counted;
    int pick;
    int k;
    for (k = 0; k < 8; k++) begin
      palette[k] = {rand_channel(), rand_channel(), rand_channel()};
    end
    counted = 0;
    while (counted < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        queue_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom));
      end else begin
        counted++;
        if (pick == 3 && clears_left > 0) begin
          queue_clear();
          clears_left--;
        end else if (pick < 60) begin
          if ($urandom_range(0, 9) < 5) begin
            color = palette[$urandom_range(0, 7)];
          end else begin
            color = {rand_channel(), rand_channel(), rand_channel()};
          end
          queue_pixel(color[23:16], color[15:8], color[7:0]);
        end else begin
          if (hit_bins.size() != 0 && $urandom_range(0, 3) != 0) begin
            spot = hit_bins[$urandom_range(0, hit_bins.size() - 1)];
          end else begin
            spot = 16'($urandom);
          end
          queue_read(spot[15:8], spot[7:0]);
        end
      end
    end
    queue_read(8'($urandom), 8'($urandom));
  endtask

  initial begin
    int phase;
    req_ch.valid = 1'b0;
    req_ch.cmd   = CMD_ADD;
    req_ch.red   = '0;
    req_ch.green = '0;
    req_ch.blue  = '0;
    req_ch.bin_u = '0;
    req_ch.bin_v = '0;
    rsp_ch.ready = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed items at the reset offset: full-scale and zero channels,
    // each clamp direction, both-zero differences, an unused command, a clear.
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_read(CHROMA_OFFSET_RST, CHROMA_OFFSET_RST);
    queue_pixel(8'd1, 8'd255, 8'd1);
    queue_pixel(8'd255, 8'd1, 8'd255);
    queue_pixel(8'd0, 8'd100, 8'd0);
    queue_pixel(8'd100, 8'd0, 8'd100);
    queue_pixel(8'd0, 8'd0, 8'd50);
    queue_pixel(8'd50, 8'd50, 8'd0);
    queue_pixel(8'd200, 8'd100, 8'd50);
    queue_item(CMD_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    queue_read(8'd255, 8'd255);
    queue_read(8'd0, 8'd0);
    queue_read(CHROMA_OFFSET_RST, 8'd0);
    queue_read(CHROMA_OFFSET_RST, 8'd255);
    queue_read(hit_bins[$][15:8], hit_bins[$][7:0]);
    queue_read(8'd0, 8'd255);
    queue_clear();
    queue_read(CHROMA_OFFSET_RST, CHROMA_OFFSET_RST);
    queue_read(8'd255, 8'd255);
    queue_pixel(8'd7, 8'd128, 8'd250);
    queue_read(hit_bins[$][15:8], hit_bins[$][7:0]);
    wait_idle();

    // Random phases, each at its own offset, extremes first.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_offset('0);
        1: write_offset('1);
        2: write_offset(CHROMA_OFFSET_RST);
        default: write_offset(OFFSET_W'($urandom));
      endcase
      queue_random_phase(PHASE_ITEMS);
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Run limit.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
